>>> hw/rtl/hmq_pkg.sv
`default_nettype none
package hmq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned IdW      = 8;
  localparam int unsigned KeyW     = 32;

  // operation codes
  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_UPDATE  = 3'd1;
  localparam logic [2:0] MODE_EXTRACT = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_IDS    = 3'd3;
  localparam logic [2:0] ST_ABSENT    = 3'd4;

  // configuration register indexes
  localparam logic CFG_HAS_IDS     = 1'b0;
  localparam logic CFG_SIGNED_KEYS = 1'b1;

  typedef struct packed {
    logic [2:0]      mode;
    logic [IdW-1:0]  item_id;
    logic [KeyW-1:0] key_value;
  } hmq_req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdW-1:0]  out_id;
    logic            out_id_valid;
    logic [KeyW-1:0] out_key;
    logic [IdxW-1:0] out_position;
    logic [CntW-1:0] entry_count;
    logic            is_empty;
  } hmq_rsp_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } hmq_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/hmq_key_cmp.sv
`default_nettype none
module hmq_key_cmp (
  input  wire logic [hmq_pkg::KeyW-1:0] a_i,
  input  wire logic [hmq_pkg::KeyW-1:0] b_i,
  input  wire logic                     signed_i,
  output logic                          less_o
);
  import hmq_pkg::*;

  logic [KeyW-1:0] a_adj, b_adj;

  // flip sign bits so one unsigned compare serves both orderings
  always_comb begin
    a_adj = a_i;
    b_adj = b_i;
    a_adj[KeyW-1] = a_i[KeyW-1] ^ signed_i;
    b_adj[KeyW-1] = b_i[KeyW-1] ^ signed_i;
    less_o = a_adj < b_adj;
  end

endmodule
`default_nettype wire

>>> hw/rtl/hmq_heap_ram.sv
`default_nettype none
module hmq_heap_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [hmq_pkg::IdxW-1:0] wa_i,
  input  wire hmq_pkg::hmq_entry_t      wd_i,
  input  wire logic [hmq_pkg::IdxW-1:0] ra0_i,
  input  wire logic [hmq_pkg::IdxW-1:0] ra1_i,
  output hmq_pkg::hmq_entry_t           rd0_o,
  output hmq_pkg::hmq_entry_t           rd1_o
);
  import hmq_pkg::*;

  hmq_entry_t mem [Capacity];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rd0_o <= mem[ra0_i];
    rd1_o <= mem[ra1_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/hmq_pos_ram.sv
`default_nettype none
module hmq_pos_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [hmq_pkg::IdW-1:0]  wa_i,
  input  wire logic [hmq_pkg::IdxW-1:0] wd_i,
  input  wire logic [hmq_pkg::IdW-1:0]  ra_i,
  output logic [hmq_pkg::IdxW-1:0]      rd_o
);
  import hmq_pkg::*;

  logic [IdxW-1:0] mem [2**IdW];

  // id to slot map, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rd_o <= mem[ra_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/indexed_min_heap_queue_unit.sv
`default_nettype none
// Indexed min-heap queue of 64 keyed entries with an id to slot map. Hold start
// until busy is low; exactly one result appears on rsp_o for one cycle with
// done_o high, and must be taken then, since the block cannot be held off.
// A new operation may start in the cycle done_o is high. The paths through
// the sequencer:
// - Clear, unused modes, extract from empty and ids-disabled refusals end at
//   dispatch.
// - Insert when full and lookup of an absent id end after the id map read;
//   lookup then reads the slot's key, and extract of the last entry ends once
//   the root is read. Insert appends at the end and rises a level at a time:
//   read the parent, compare and move the parent down, then write the map.
// - Update in place rises like insert. Otherwise it sinks a level at a time:
//   read both children, select the smaller, compare and move it up, then
//   write the map.
// - Extract moves the last entry to the root and sinks it the same way as
//   update.
// The slowest operation is an update that sinks from the root to the deepest
// leaf of a full heap. Each level is paced by the heap memory's single write
// port with registered reads and by the one key comparator shared by the
// compare steps.
module indexed_min_heap_queue_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire hmq_pkg::hmq_req_t req_i,
  output logic                   done_o,
  output hmq_pkg::hmq_rsp_t      rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic              cfg_data_i
);
  import hmq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FIND, S_REKEY, S_LOOKUP, S_EXTRACT, S_UP_RD, S_UP_CMP,
    S_UP_POS, S_DN_RD, S_DN_SEL, S_DN_CMP, S_DN_POS, S_FINISH
  } state_e;

  state_e          state_q;
  logic [2:0]      mode_q;
  logic [IdW-1:0]  id_q;
  logic [KeyW-1:0] key_q;
  logic            has_ids_q, signed_q;
  logic [CntW-1:0] fill_q;
  logic [2**IdW-1:0] present_q;
  logic [IdxW-1:0] hole_q, chi_q, pos_q;
  hmq_entry_t      ent_q, ch_q;
  logic            moved_q, down_q, done_q;
  logic [2:0]      status_q;
  logic [IdW-1:0]  oid_q;
  logic            ovalid_q;
  logic [KeyW-1:0] okey_q;

  logic            heap_we;
  logic [IdxW-1:0] heap_wa, ra0, ra1;
  hmq_entry_t      heap_wd, rd0, rd1;
  logic            pos_we;
  logic [IdW-1:0]  pos_wa;
  logic [IdxW-1:0] pos_wd, pos_rd;
  logic [KeyW-1:0] cmp_a, cmp_b;
  logic            less;

  logic [IdxW-1:0] parent;
  logic [IdxW:0]   c1;
  logic [IdxW+1:0] c2;
  logic            found;
  logic            full;

  assign parent = (hole_q - IdxW'(1)) >> 1;
  assign c1     = {hole_q, 1'b1};
  assign c2     = {1'b0, c1} + (IdxW+2)'(1);
  assign found  = present_q[id_q] && ({1'b0, pos_rd} < fill_q);
  assign full   = fill_q == CntW'(Capacity);

  hmq_heap_ram u_heap (
    .clk_i (clk_i),
    .we_i  (heap_we),
    .wa_i  (heap_wa),
    .wd_i  (heap_wd),
    .ra0_i (ra0),
    .ra1_i (ra1),
    .rd0_o (rd0),
    .rd1_o (rd1)
  );

  hmq_pos_ram u_pos (
    .clk_i (clk_i),
    .we_i  (pos_we),
    .wa_i  (pos_wa),
    .wd_i  (pos_wd),
    .ra_i  (id_q),
    .rd_o  (pos_rd)
  );

  hmq_key_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .signed_i (signed_q),
    .less_o   (less)
  );

  // memory addressing and comparator operands per step
  always_comb begin
    heap_we = 1'b0;
    heap_wa = hole_q;
    heap_wd = ent_q;
    pos_we  = 1'b0;
    pos_wa  = ent_q.id;
    pos_wd  = hole_q;
    ra0     = c1[IdxW-1:0];
    ra1     = c2[IdxW-1:0];
    cmp_a   = ent_q.key;
    cmp_b   = rd0.key;
    case (state_q)
      S_DISPATCH: begin
        ra0 = '0;
        ra1 = fill_q[IdxW-1:0] - IdxW'(1);
      end
      S_FIND: begin
        ra0 = pos_rd;
        if ((mode_q == MODE_INSERT) && has_ids_q && !found && !full) begin
          pos_we = 1'b1;
          pos_wa = id_q;
          pos_wd = fill_q[IdxW-1:0];
        end else if ((mode_q == MODE_UPDATE) && !found && !full) begin
          pos_we = 1'b1;
          pos_wa = id_q;
          pos_wd = fill_q[IdxW-1:0];
        end
      end
      S_EXTRACT: begin
        pos_wa = rd1.id;
        pos_wd = '0;
        pos_we = has_ids_q && (fill_q > CntW'(1));
      end
      S_UP_RD: begin
        ra0 = parent;
      end
      S_UP_CMP: begin
        if (less) begin
          heap_we = 1'b1;
          heap_wd = rd0;
          pos_we  = has_ids_q;
          pos_wa  = rd0.id;
        end
      end
      S_UP_POS: begin
        pos_we = has_ids_q;
        pos_wd = parent;
      end
      S_DN_SEL: begin
        cmp_a = rd0.key;
        cmp_b = rd1.key;
      end
      S_DN_CMP: begin
        cmp_a = ch_q.key;
        cmp_b = ent_q.key;
        if (less) begin
          heap_we = 1'b1;
          heap_wd = ch_q;
          pos_we  = has_ids_q;
          pos_wd  = chi_q;
        end
      end
      S_DN_POS: begin
        pos_we = has_ids_q;
        pos_wa = ch_q.id;
      end
      S_FINISH: begin
        heap_we = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer, state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      has_ids_q <= 1'b1;
      signed_q  <= 1'b0;
      fill_q    <= '0;
      present_q <= '0;
      done_q    <= 1'b0;
      moved_q   <= 1'b0;
      down_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HAS_IDS) begin
          has_ids_q <= cfg_data_i;
        end else begin
          signed_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q   <= req_i.mode;
            id_q     <= req_i.item_id;
            key_q    <= req_i.key_value;
            status_q <= ST_OK;
            oid_q    <= '0;
            ovalid_q <= 1'b0;
            okey_q   <= '0;
            pos_q    <= '0;
            state_q  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
          case (mode_q)
            MODE_INSERT: begin
              state_q <= S_FIND;
              done_q  <= 1'b0;
            end
            MODE_UPDATE, MODE_LOOKUP: begin
              if (has_ids_q) begin
                state_q <= S_FIND;
                done_q  <= 1'b0;
              end else begin
                status_q <= ST_NO_IDS;
              end
            end
            MODE_EXTRACT: begin
              if (fill_q == '0) begin
                status_q <= ST_EMPTY;
              end else begin
                state_q <= S_EXTRACT;
                done_q  <= 1'b0;
              end
            end
            MODE_CLEAR: begin
              fill_q    <= '0;
              present_q <= '0;
            end
            default: ;
          endcase
        end
        S_FIND: begin
          ent_q   <= '{id: id_q, key: key_q};
          moved_q <= 1'b0;
          if (mode_q == MODE_LOOKUP) begin
            if (found) begin
              pos_q   <= pos_rd;
              state_q <= S_LOOKUP;
            end else begin
              status_q <= ST_ABSENT;
              state_q  <= S_IDLE;
              done_q   <= 1'b1;
            end
          end else if (has_ids_q && found) begin
            // re-key an entry in place
            hole_q  <= pos_rd;
            down_q  <= 1'b1;
            state_q <= S_REKEY;
          end else if (full) begin
            status_q <= ST_FULL;
            state_q  <= S_IDLE;
            done_q   <= 1'b1;
          end else begin
            // append at the end
            hole_q <= fill_q[IdxW-1:0];
            fill_q <= fill_q + CntW'(1);
            down_q <= 1'b0;
            if (has_ids_q) begin
              present_q[id_q] <= 1'b1;
            end
            state_q <= S_UP_RD;
          end
        end
        S_REKEY: begin
          // keep the id stored in the slot; a stale map may name another id
          ent_q.id <= rd0.id;
          state_q  <= S_UP_RD;
        end
        S_LOOKUP: begin
          oid_q    <= id_q;
          ovalid_q <= 1'b1;
          okey_q   <= rd0.key;
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
        end
        S_EXTRACT: begin
          okey_q <= rd0.key;
          if (has_ids_q) begin
            oid_q            <= rd0.id;
            ovalid_q         <= 1'b1;
            present_q[rd0.id] <= 1'b0;
          end
          ent_q  <= rd1;
          hole_q <= '0;
          fill_q <= fill_q - CntW'(1);
          if (fill_q > CntW'(1)) begin
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_UP_RD: begin
          if (hole_q == '0) begin
            state_q <= (down_q && !moved_q) ? S_DN_RD : S_FINISH;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (less) begin
            state_q <= S_UP_POS;
          end else begin
            state_q <= (down_q && !moved_q) ? S_DN_RD : S_FINISH;
          end
        end
        S_UP_POS: begin
          hole_q  <= parent;
          moved_q <= 1'b1;
          state_q <= S_UP_RD;
        end
        S_DN_RD: begin
          state_q <= ({1'b0, c1} < {1'b0, fill_q}) ? S_DN_SEL : S_FINISH;
        end
        S_DN_SEL: begin
          // right child wins unless the left one is strictly smaller
          if ((c2 < {1'b0, fill_q}) && !less) begin
            ch_q  <= rd1;
            chi_q <= c2[IdxW-1:0];
          end else begin
            ch_q  <= rd0;
            chi_q <= c1[IdxW-1:0];
          end
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          state_q <= less ? S_DN_POS : S_FINISH;
        end
        S_DN_POS: begin
          hole_q  <= chi_q;
          state_q <= S_DN_RD;
        end
        S_FINISH: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;

  // drive the transaction fields
  always_comb begin
    rsp_o.status       = status_q;
    rsp_o.out_id       = oid_q;
    rsp_o.out_id_valid = ovalid_q;
    rsp_o.out_key      = okey_q;
    rsp_o.out_position = pos_q;
    rsp_o.entry_count  = fill_q;
    rsp_o.is_empty     = fill_q == '0;
  end

endmodule
`default_nettype wire

>>> dv/indexed_min_heap_queue_checker.sv
`default_nettype none
module indexed_min_heap_queue_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire hmq_pkg::hmq_req_t req_i,
  input  wire logic              done_o,
  input  wire hmq_pkg::hmq_rsp_t rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic              cfg_data_i,
  output int unsigned            fail_count,
  output int unsigned            pending_count
);
  import hmq_pkg::*;

  // shadow of the heap and id map
  logic [KeyW-1:0] heap_key [Capacity];
  logic [IdW-1:0]  heap_id  [Capacity];
  int unsigned     id_slot  [256];
  bit              id_live  [256];
  int unsigned     fill;
  bit              ids_on;
  bit              keys_signed;

  hmq_rsp_t expected_rsp_q[$];

  assign pending_count = expected_rsp_q.size();

  function automatic bit key_lt(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    if (keys_signed) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [KeyW-1:0] tk;
    logic [IdW-1:0]  ti;
    tk = heap_key[a]; ti = heap_id[a];
    heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
    heap_key[b] = tk; heap_id[b] = ti;
    if (ids_on) begin
      id_slot[heap_id[a]] = a;
      id_slot[heap_id[b]] = b;
    end
  endfunction

  function automatic bit rise(int unsigned c);
    int unsigned p;
    bit moved;
    moved = 0;
    while (c > 0) begin
      p = (c - 1) / 2;
      if (!key_lt(heap_key[c], heap_key[p])) break;
      swap_entries(c, p);
      moved = 1;
      c = p;
    end
    return moved;
  endfunction

  function automatic void sink(int unsigned p);
    int unsigned c1, c;
    while (p < fill) begin
      c1 = 2 * p + 1;
      if (c1 >= fill) break;
      c = c1;
      if (c1 + 1 < fill && !key_lt(heap_key[c1], heap_key[c1 + 1])) c = c1 + 1;
      if (!key_lt(heap_key[c], heap_key[p])) break;
      swap_entries(c, p);
      p = c;
    end
  endfunction

  function automatic int find_slot(logic [IdW-1:0] id);
    if (id_live[id] && id_slot[id] < fill) return int'(id_slot[id]);
    return -1;
  endfunction

  function automatic logic [2:0] push_entry(logic [IdW-1:0] id, logic [KeyW-1:0] key);
    if (fill >= Capacity) return ST_FULL;
    heap_key[fill] = key;
    heap_id[fill]  = id;
    if (ids_on) begin
      id_slot[id] = fill;
      id_live[id] = 1;
    end
    fill++;
    void'(rise(fill - 1));
    return ST_OK;
  endfunction

  function automatic logic [2:0] rekey(logic [IdW-1:0] id, logic [KeyW-1:0] key);
    int pos;
    pos = find_slot(id);
    if (pos < 0) return push_entry(id, key);
    heap_key[pos] = key;
    if (!rise(pos)) sink(pos);
    return ST_OK;
  endfunction

  function automatic hmq_rsp_t predict_heap_op(hmq_req_t rq);
    hmq_rsp_t r;
    int pos;
    logic [IdW-1:0] rid;
    r = '0;
    case (rq.mode)
      MODE_INSERT:
        r.status = (ids_on && find_slot(rq.item_id) >= 0) ?
                   rekey(rq.item_id, rq.key_value) : push_entry(rq.item_id, rq.key_value);
      MODE_UPDATE:
        r.status = ids_on ? rekey(rq.item_id, rq.key_value) : ST_NO_IDS;
      MODE_EXTRACT:
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          rid = heap_id[0];
          r.out_key = heap_key[0];
          if (ids_on) begin
            r.out_id = rid;
            r.out_id_valid = 1;
            id_live[rid] = 0;
          end
          heap_key[0] = heap_key[fill - 1];
          heap_id[0]  = heap_id[fill - 1];
          fill--;
          if (ids_on && fill > 0) id_slot[heap_id[0]] = 0;
          sink(0);
        end
      MODE_CLEAR: begin
        fill = 0;
        foreach (id_live[i]) id_live[i] = 0;
      end
      MODE_LOOKUP:
        if (!ids_on) begin
          r.status = ST_NO_IDS;
        end else begin
          pos = find_slot(rq.item_id);
          if (pos < 0) begin
            r.status = ST_ABSENT;
          end else begin
            r.out_id = rq.item_id;
            r.out_id_valid = 1;
            r.out_key = heap_key[pos];
            r.out_position = pos[IdxW-1:0];
          end
        end
      default: ;
    endcase
    r.entry_count = fill[CntW-1:0];
    r.is_empty = (fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // predict on accepted transactions, compare on each result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    hmq_rsp_t w;
    if (!rst_ni) begin
      fill = 0;
      ids_on = 1;
      keys_signed = 0;
      foreach (id_live[i]) id_live[i] = 0;
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(rsp_o.entry_count), 64'(0));
        end else begin
          w = expected_rsp_q.pop_front();
          if (rsp_o.status != w.status) report_mismatch("status", rsp_o.status, w.status);
          if (rsp_o.out_id != w.out_id) report_mismatch("out_id", rsp_o.out_id, w.out_id);
          if (rsp_o.out_id_valid != w.out_id_valid)
            report_mismatch("out_id_valid", rsp_o.out_id_valid, w.out_id_valid);
          if (rsp_o.out_key != w.out_key) report_mismatch("out_key", rsp_o.out_key, w.out_key);
          if (rsp_o.out_position != w.out_position)
            report_mismatch("out_position", rsp_o.out_position, w.out_position);
          if (rsp_o.entry_count != w.entry_count)
            report_mismatch("entry_count", rsp_o.entry_count, w.entry_count);
          if (rsp_o.is_empty != w.is_empty)
            report_mismatch("is_empty", rsp_o.is_empty, w.is_empty);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HAS_IDS) ids_on = cfg_data_i;
        else keys_signed = cfg_data_i;
      end
      if (start && !busy) expected_rsp_q.push_back(predict_heap_op(req_i));
    end
  end
endmodule
`default_nettype wire

>>> dv/indexed_min_heap_queue_unit_tb.sv
`default_nettype none
module indexed_min_heap_queue_unit_tb;
  import hmq_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  hmq_req_t    req_i = '0;
  logic        done_o;
  hmq_rsp_t    rsp_o;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic        cfg_data_i = 0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned quiet_cycles;
  bit          calm;

  localparam int unsigned WatchdogLimit = 2000;

  indexed_min_heap_queue_unit dut (.*);
  indexed_min_heap_queue_checker u_checker (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles with no accepted transaction and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // send one transaction and hold start until it is taken
  task automatic issue_op(logic [2:0] mode, logic [IdW-1:0] id, logic [KeyW-1:0] key);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1;
    req_i <= '{mode: mode, item_id: id, key_value: key};
    // busy is stable mid-cycle; once low, the next edge takes the transaction
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // random phase: mostly inserts and updates, ids from 0 to id_span or at random
  task automatic random_phase(int unsigned n, int unsigned id_span);
    int unsigned r;
    logic [2:0] m;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) m = MODE_INSERT;
      else if (r < 55) m = MODE_UPDATE;
      else if (r < 80) m = MODE_EXTRACT;
      else if (r < 92) m = MODE_LOOKUP;
      else if (r < 94) m = MODE_CLEAR;
      else m = 3'($urandom_range(5, 7));
      issue_op(m, (r[0] ? 8'($urandom) : 8'($urandom_range(0, id_span))), pick_key());
    end
  endtask

  initial begin
    calm = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: errors on empty, extremes, every mode
    issue_op(MODE_EXTRACT, 0, 0);
    issue_op(MODE_LOOKUP, 8'hff, 0);
    issue_op(MODE_INSERT, 8'h00, 32'hffff_ffff);
    issue_op(MODE_INSERT, 8'hff, 32'h0);
    issue_op(MODE_INSERT, 8'h55, 32'h8000_0000);
    issue_op(MODE_INSERT, 8'haa, 32'h7fff_ffff);
    issue_op(MODE_INSERT, 8'h11, 32'h7fff_ffff);
    issue_op(MODE_INSERT, 8'h55, 32'h1);
    issue_op(MODE_UPDATE, 8'h00, 32'h0);
    issue_op(MODE_UPDATE, 8'hff, 32'hffff_fff0);
    issue_op(MODE_UPDATE, 8'h77, 32'h5);
    issue_op(MODE_LOOKUP, 8'hff, 0);
    issue_op(MODE_LOOKUP, 8'h12, 0);
    issue_op(3'd5, 0, 0);
    issue_op(3'd7, 8'hff, 32'hffff_ffff);
    issue_op(MODE_EXTRACT, 0, 0);
    issue_op(MODE_EXTRACT, 0, 0);
    issue_op(MODE_CLEAR, 0, 0);
    issue_op(MODE_LOOKUP, 8'h00, 0);
    // fill to capacity, then overflow
    for (int unsigned k = 0; k < Capacity; k++) issue_op(MODE_INSERT, 8'(k), pick_key());
    issue_op(MODE_INSERT, 8'hc0, 0);
    issue_op(MODE_UPDATE, 8'hc1, 0);
    wait_drained();

    // signed keys, random traffic, then pause until drained
    write_cfg(CFG_SIGNED_KEYS, 1);
    random_phase(300, 40);
    wait_drained();

    // ids off, with entries left over so the map goes stale
    write_cfg(CFG_HAS_IDS, 0);
    random_phase(200, 40);
    wait_drained();
    write_cfg(CFG_HAS_IDS, 1);
    write_cfg(CFG_SIGNED_KEYS, 0);
    random_phase(300, 255);
    wait_drained();
    write_cfg(CFG_SIGNED_KEYS, 1);
    random_phase(250, 20);

    // final stretch with no idling
    calm = 1;
    random_phase(150, 63);
    wait_drained();
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/hmq_pkg.sv
hw/rtl/hmq_key_cmp.sv
hw/rtl/hmq_heap_ram.sv
hw/rtl/hmq_pos_ram.sv
hw/rtl/indexed_min_heap_queue_unit.sv
dv/indexed_min_heap_queue_checker.sv
dv/indexed_min_heap_queue_unit_tb.sv
